@@ rtl/mrsc_pkg.sv @@
`default_nettype none

package mrsc_pkg;

  // Default geometry: signed Q16.16 values, 16-bit segment count
  localparam int FRAC_BITS_DEF   = 16;
  localparam int VALUE_WIDTH_DEF = 32;
  localparam int COUNT_WIDTH_DEF = 16;

  // Width of the running sum of the terms
  localparam int ACC_WIDTH = 64;

  // Configuration register indexes
  localparam int CFG_INDEX_W = 2;
  localparam logic [CFG_INDEX_W-1:0] REG_COEF_CUBIC    = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_COEF_SQUARE   = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_COEF_LINEAR   = 2'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_COEF_CONSTANT = 2'd3;

  // Result sideband bits
  localparam int USER_W       = 2;
  localparam int USER_SAT_BIT = 0;
  localparam int USER_BAD_BIT = 1;

  // Sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIVIDE,
    ST_ISSUE,
    ST_DRAIN,
    ST_FINISH
  } state_t;

  // Control bits that travel with each midpoint through the pipeline
  typedef struct packed {
    logic valid;
    logic last;
    logic clip;
  } pt_ctl_t;

endpackage

`default_nettype wire

@@ rtl/mrsc_div.sv @@
`default_nettype none

module mrsc_div import mrsc_pkg::*; #(
  parameter int VALUE_WIDTH = VALUE_WIDTH_DEF,
  parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   start,
  input  wire logic [VALUE_WIDTH-1:0] dividend,
  input  wire logic [COUNT_WIDTH-1:0] divisor,
  output logic                        done,
  output logic [VALUE_WIDTH-1:0]      quotient
);

  localparam int CNT_W = $clog2(VALUE_WIDTH + 1);

  logic [VALUE_WIDTH-1:0] quo_r, quo_nxt;
  logic [COUNT_WIDTH-1:0] rem_r, rem_nxt;
  logic [COUNT_WIDTH-1:0] den_r, den_nxt;
  logic [CNT_W-1:0]       cnt_r, cnt_nxt;
  logic                   busy_r, busy_nxt;
  logic                   done_r, done_nxt;
  logic [COUNT_WIDTH:0]   trial;
  logic [COUNT_WIDTH:0]   trial_sub;

  // One quotient bit per cycle, restoring division on magnitudes
  always_comb begin
    trial     = {rem_r, quo_r[VALUE_WIDTH-1]};
    trial_sub = trial - {1'b0, den_r};
    quo_nxt   = quo_r;
    rem_nxt   = rem_r;
    den_nxt   = den_r;
    cnt_nxt   = cnt_r;
    busy_nxt  = busy_r;
    done_nxt  = 1'b0;
    if (start) begin
      quo_nxt  = dividend;
      rem_nxt  = '0;
      den_nxt  = divisor;
      cnt_nxt  = CNT_W'(VALUE_WIDTH);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (!trial_sub[COUNT_WIDTH]) begin
        rem_nxt = trial_sub[COUNT_WIDTH-1:0];
        quo_nxt = {quo_r[VALUE_WIDTH-2:0], 1'b1};
      end else begin
        rem_nxt = trial[COUNT_WIDTH-1:0];
        quo_nxt = {quo_r[VALUE_WIDTH-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == CNT_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  // Datapath
  always_ff @(posedge clk) begin
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    den_r <= den_nxt;
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule

`default_nettype wire

@@ rtl/mrsc_mul.sv @@
`default_nettype none

module mrsc_mul import mrsc_pkg::*; #(
  parameter int WIDTH = VALUE_WIDTH_DEF
) (
  input  wire logic                    clk,
  input  wire logic signed [WIDTH-1:0] a,
  input  wire logic signed [WIDTH-1:0] b,
  output logic signed [2*WIDTH-1:0]    prod
);

  localparam int LW = WIDTH / 2;
  localparam int HW = WIDTH - LW;
  localparam int PW = 2 * WIDTH;
  localparam int XW = HW + LW + 1;

  logic signed [HW-1:0]   a_hi, b_hi;
  logic signed [LW:0]     a_lo, b_lo;
  logic signed [2*HW-1:0] pp_hh_r, pp_hh_nxt;
  logic signed [XW-1:0]   pp_hl_r, pp_hl_nxt;
  logic signed [XW-1:0]   pp_lh_r, pp_lh_nxt;
  logic [2*LW-1:0]        pp_ll_r, pp_ll_nxt;
  logic signed [PW-1:0]   prod_r, prod_nxt;

  // Stage one: signed high halves, unsigned low halves, four partial products
  always_comb begin
    a_hi      = a[WIDTH-1:LW];
    b_hi      = b[WIDTH-1:LW];
    a_lo      = {1'b0, a[LW-1:0]};
    b_lo      = {1'b0, b[LW-1:0]};
    pp_hh_nxt = (2*HW)'(a_hi) * (2*HW)'(b_hi);
    pp_hl_nxt = XW'(a_hi) * XW'(b_lo);
    pp_lh_nxt = XW'(a_lo) * XW'(b_hi);
    pp_ll_nxt = (2*LW)'(a[LW-1:0]) * (2*LW)'(b[LW-1:0]);
  end

  // Stage two: align and add the partial products
  always_comb begin
    prod_nxt = (PW'(pp_hh_r) <<< (2*LW)) + (PW'(pp_hl_r) <<< LW)
             + (PW'(pp_lh_r) <<< LW) + PW'(pp_ll_r);
  end

  always_ff @(posedge clk) begin
    pp_hh_r <= pp_hh_nxt;
    pp_hl_r <= pp_hl_nxt;
    pp_lh_r <= pp_lh_nxt;
    pp_ll_r <= pp_ll_nxt;
    prod_r  <= prod_nxt;
  end

  assign prod = prod_r;

endmodule

`default_nettype wire

@@ rtl/mrsc_horner.sv @@
`default_nettype none

module mrsc_horner import mrsc_pkg::*; #(
  parameter int FRAC_BITS   = FRAC_BITS_DEF,
  parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire pt_ctl_t                       in_ctl,
  input  wire logic signed [VALUE_WIDTH-1:0] in_acc,
  input  wire logic signed [VALUE_WIDTH-1:0] in_x,
  input  wire logic signed [VALUE_WIDTH-1:0] coef,
  output pt_ctl_t                            out_ctl,
  output logic signed [VALUE_WIDTH-1:0]      out_acc,
  output logic signed [VALUE_WIDTH-1:0]      out_x
);

  localparam int PW   = 2 * VALUE_WIDTH;
  localparam int SHW  = PW - FRAC_BITS;
  localparam int SW   = SHW + 1;
  localparam int TOPW = SW - VALUE_WIDTH + 1;
  localparam logic signed [VALUE_WIDTH-1:0] VAL_MAX = {1'b0, {(VALUE_WIDTH-1){1'b1}}};
  localparam logic signed [VALUE_WIDTH-1:0] VAL_MIN = {1'b1, {(VALUE_WIDTH-1){1'b0}}};

  logic signed [PW-1:0]          prod;
  pt_ctl_t                       ctl_d1_r, ctl_d2_r, ctl_r, ctl_nxt;
  logic signed [VALUE_WIDTH-1:0] x_d1_r, x_d2_r, x_r;
  logic signed [VALUE_WIDTH-1:0] acc_r, acc_nxt;
  logic signed [SHW-1:0]         prod_sh;
  logic signed [SW-1:0]          sum;
  logic [TOPW-1:0]               sum_top;
  logic                          fits;

  // Two-stage product of the running value and the midpoint
  mrsc_mul #(
    .WIDTH (VALUE_WIDTH)
  ) u_mul (
    .clk  (clk),
    .a    (in_acc),
    .b    (in_x),
    .prod (prod)
  );

  // Floor the product back to the fixed-point grid, add the coefficient, clamp
  always_comb begin
    prod_sh = prod[PW-1:FRAC_BITS];
    sum     = SW'(prod_sh) + SW'(coef);
    sum_top = sum[SW-1:VALUE_WIDTH-1];
    fits    = (&sum_top) | (~|sum_top);
    if (fits) begin
      acc_nxt = sum[VALUE_WIDTH-1:0];
    end else if (sum[SW-1]) begin
      acc_nxt = VAL_MIN;
    end else begin
      acc_nxt = VAL_MAX;
    end
    ctl_nxt      = ctl_d2_r;
    ctl_nxt.clip = ctl_d2_r.clip | ~fits;
  end

  // Valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_d1_r <= '0;
      ctl_d2_r <= '0;
      ctl_r    <= '0;
    end else begin
      ctl_d1_r <= in_ctl;
      ctl_d2_r <= ctl_d1_r;
      ctl_r    <= ctl_nxt;
    end
  end

  // Carry the midpoint along with the product
  always_ff @(posedge clk) begin
    x_d1_r <= in_x;
    x_d2_r <= x_d1_r;
    x_r    <= x_d2_r;
    acc_r  <= acc_nxt;
  end

  assign out_ctl = ctl_r;
  assign out_acc = acc_r;
  assign out_x   = x_r;

endmodule

`default_nettype wire

@@ rtl/mrsc_term.sv @@
`default_nettype none

module mrsc_term import mrsc_pkg::*; #(
  parameter int FRAC_BITS   = FRAC_BITS_DEF,
  parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire pt_ctl_t                       in_ctl,
  input  wire logic signed [VALUE_WIDTH-1:0] y,
  input  wire logic signed [VALUE_WIDTH-1:0] w,
  output pt_ctl_t                            out_ctl,
  output logic signed [ACC_WIDTH-1:0]        term
);

  localparam int PW   = 2 * VALUE_WIDTH;
  localparam int SHW  = PW - FRAC_BITS;
  localparam int EW   = ((SHW > ACC_WIDTH) ? SHW : ACC_WIDTH) + 1;
  localparam int TOPW = EW - ACC_WIDTH + 1;
  localparam logic signed [ACC_WIDTH-1:0] ACC_MAX = {1'b0, {(ACC_WIDTH-1){1'b1}}};
  localparam logic signed [ACC_WIDTH-1:0] ACC_MIN = {1'b1, {(ACC_WIDTH-1){1'b0}}};

  logic signed [PW-1:0]        prod;
  pt_ctl_t                     ctl_d1_r, ctl_d2_r, ctl_r, ctl_nxt;
  logic signed [SHW-1:0]       prod_sh;
  logic signed [EW-1:0]        prod_ext;
  logic [TOPW-1:0]             ext_top;
  logic                        fits;
  logic signed [ACC_WIDTH-1:0] term_r, term_nxt;

  // Two-stage product of the function value and the step width
  mrsc_mul #(
    .WIDTH (VALUE_WIDTH)
  ) u_mul (
    .clk  (clk),
    .a    (y),
    .b    (w),
    .prod (prod)
  );

  // Floor back to the grid and saturate to the sum width
  always_comb begin
    prod_sh  = prod[PW-1:FRAC_BITS];
    prod_ext = EW'(prod_sh);
    ext_top  = prod_ext[EW-1:ACC_WIDTH-1];
    fits     = (&ext_top) | (~|ext_top);
    if (fits) begin
      term_nxt = prod_ext[ACC_WIDTH-1:0];
    end else if (prod_ext[EW-1]) begin
      term_nxt = ACC_MIN;
    end else begin
      term_nxt = ACC_MAX;
    end
    ctl_nxt      = ctl_d2_r;
    ctl_nxt.clip = ctl_d2_r.clip | ~fits;
  end

  // Valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_d1_r <= '0;
      ctl_d2_r <= '0;
      ctl_r    <= '0;
    end else begin
      ctl_d1_r <= in_ctl;
      ctl_d2_r <= ctl_d1_r;
      ctl_r    <= ctl_nxt;
    end
  end

  always_ff @(posedge clk) begin
    term_r <= term_nxt;
  end

  assign out_ctl = ctl_r;
  assign term    = term_r;

endmodule

`default_nettype wire

@@ rtl/midpoint_riemann_sum_cubic_core.sv @@
// A zero segment count skips the divider and the pipeline and goes straight to the finish state.
// Throughput: one item at a time. The step-width divider yields one bit per cycle, then the
//   sequencer feeds one midpoint per cycle into a 13-stage Horner/product/sum pipeline.
// The next word can be taken once a result has moved into the output register and the sequencer is back in idle.
// Reset: synchronous, rst_n low clears the sequencer, valid bits and coefficients to zero.
`default_nettype none

module midpoint_riemann_sum_cubic_core import mrsc_pkg::*; #(
  parameter int FRAC_BITS   = FRAC_BITS_DEF,
  parameter int VALUE_WIDTH = VALUE_WIDTH_DEF,
  parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  // Configuration write port
  input  wire logic                   cfg_we,
  input  wire logic [CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [VALUE_WIDTH-1:0] cfg_data,
  // Input stream
  input  wire logic                   in_tvalid,
  output logic                        in_tready,
  // in_tdata, low bit up: lower_bound, upper_bound, segment_count, zero fill
  input  wire logic [((2*VALUE_WIDTH+COUNT_WIDTH+7)/8)*8-1:0] in_tdata,
  // Result stream
  output logic                        out_tvalid,
  input  wire logic                   out_tready,
  // out_tdata, low bit up: riemann_sum, zero fill
  output logic [((VALUE_WIDTH+7)/8)*8-1:0] out_tdata,
  // out_tuser, low bit up: saturated, bad_count
  output logic [USER_W-1:0]           out_tuser
);

  localparam int OUT_W = ((VALUE_WIDTH + 7) / 8) * 8;
  localparam int XW    = VALUE_WIDTH + 2;
  localparam int XTOPW = XW - VALUE_WIDTH + 1;
  localparam int ATOPW = ACC_WIDTH - VALUE_WIDTH + 1;
  localparam logic signed [VALUE_WIDTH-1:0] VAL_MAX = {1'b0, {(VALUE_WIDTH-1){1'b1}}};
  localparam logic signed [VALUE_WIDTH-1:0] VAL_MIN = {1'b1, {(VALUE_WIDTH-1){1'b0}}};
  localparam logic signed [ACC_WIDTH-1:0]   ACC_MAX = {1'b0, {(ACC_WIDTH-1){1'b1}}};
  localparam logic signed [ACC_WIDTH-1:0]   ACC_MIN = {1'b1, {(ACC_WIDTH-1){1'b0}}};

  // Coefficients
  logic signed [VALUE_WIDTH-1:0] coef_cubic_r, coef_square_r, coef_linear_r, coef_constant_r;

  // Sequencer
  state_t state_r, state_nxt;
  logic   in_accept;
  logic   div_start;
  logic   w_load;
  logic   issue_en;
  logic   out_load;
  logic   issue_last;

  // Input word decode
  logic signed [VALUE_WIDTH-1:0] in_lower, in_upper;
  logic [COUNT_WIDTH-1:0]        in_count;
  logic signed [VALUE_WIDTH:0]   in_diff, in_diff_neg;
  logic [VALUE_WIDTH-1:0]        in_mag;

  // Item registers
  logic signed [VALUE_WIDTH-1:0] lower_r;
  logic [COUNT_WIDTH-1:0]        n_r;
  logic                          bad_r, neg_r, item_clip_r;
  logic signed [VALUE_WIDTH-1:0] w_r, w_nxt;
  logic signed [VALUE_WIDTH-1:0] w_half;
  logic                          w_ovf;
  logic [VALUE_WIDTH-1:0]        q_neg;
  logic signed [XW-1:0]          x_r, x_nxt;
  logic [COUNT_WIDTH-1:0]        idx_r, idx_nxt;
  logic [XTOPW-1:0]              x_top;
  logic                          x_fits;

  // Divider
  logic                   div_done;
  logic [VALUE_WIDTH-1:0] div_quo;

  // Midpoint issue stage and pipeline
  pt_ctl_t                       pt_ctl_r, pt_ctl_nxt;
  logic signed [VALUE_WIDTH-1:0] pt_x_r, pt_x_nxt;
  pt_ctl_t                       h0_ctl, h1_ctl, h2_ctl, term_ctl;
  logic signed [VALUE_WIDTH-1:0] h0_acc, h1_acc, h2_acc;
  logic signed [VALUE_WIDTH-1:0] h0_x, h1_x, h2_x;
  logic signed [ACC_WIDTH-1:0]   term_val;

  // Running sum
  logic signed [ACC_WIDTH-1:0] acc_r, acc_nxt;
  logic signed [ACC_WIDTH:0]   acc_sum;
  logic                        acc_ovf;
  logic                        acc_clip_r, acc_clip_nxt;
  logic                        acc_done_r, acc_done_nxt;
  logic [ATOPW-1:0]            acc_top;
  logic                        acc_fits;

  // Output register
  logic                   out_tvalid_r;
  logic [VALUE_WIDTH-1:0] out_sum_r, out_sum_nxt;
  logic                   out_sat_r, out_sat_nxt;
  logic                   out_bad_r;

  // Configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      coef_cubic_r    <= '0;
      coef_square_r   <= '0;
      coef_linear_r   <= '0;
      coef_constant_r <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_COEF_CUBIC:    coef_cubic_r    <= cfg_data;
        REG_COEF_SQUARE:   coef_square_r   <= cfg_data;
        REG_COEF_LINEAR:   coef_linear_r   <= cfg_data;
        REG_COEF_CONSTANT: coef_constant_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // Split the input word and form the interval length magnitude
  always_comb begin
    in_lower    = in_tdata[VALUE_WIDTH-1:0];
    in_upper    = in_tdata[2*VALUE_WIDTH-1:VALUE_WIDTH];
    in_count    = in_tdata[2*VALUE_WIDTH+COUNT_WIDTH-1:2*VALUE_WIDTH];
    in_diff     = (VALUE_WIDTH+1)'(in_upper) - (VALUE_WIDTH+1)'(in_lower);
    in_diff_neg = -in_diff;
    in_mag      = in_diff[VALUE_WIDTH] ? in_diff_neg[VALUE_WIDTH-1:0]
                                       : in_diff[VALUE_WIDTH-1:0];
  end

  assign in_accept  = in_tvalid & in_tready;
  assign issue_last = (idx_r == n_r - 1'b1);

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_accept) begin
          state_nxt = (in_count == '0) ? ST_FINISH : ST_DIVIDE;
        end
      end
      ST_DIVIDE: begin
        if (div_done) state_nxt = ST_ISSUE;
      end
      ST_ISSUE: begin
        if (issue_last) state_nxt = ST_DRAIN;
      end
      ST_DRAIN: begin
        if (acc_done_r) state_nxt = ST_FINISH;
      end
      ST_FINISH: begin
        if (out_load) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Sequencer outputs
  always_comb begin
    in_tready = 1'b0;
    div_start = 1'b0;
    w_load    = 1'b0;
    issue_en  = 1'b0;
    out_load  = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_tready = 1'b1;
        div_start = in_tvalid & (in_count != '0);
      end
      ST_DIVIDE: w_load   = div_done;
      ST_ISSUE:  issue_en = 1'b1;
      ST_DRAIN:  ;
      ST_FINISH: out_load = ~out_tvalid_r | out_tready;
      default: ;
    endcase
  end

  // Step width, truncated toward zero
  mrsc_div #(
    .VALUE_WIDTH (VALUE_WIDTH),
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (in_mag),
    .divisor  (in_count),
    .done     (div_done),
    .quotient (div_quo)
  );

  // Apply the sign to the width, clamp it, and halve it for the first midpoint
  always_comb begin
    q_neg = -div_quo;
    if (neg_r) begin
      w_ovf = div_quo[VALUE_WIDTH-1] & (|div_quo[VALUE_WIDTH-2:0]);
      w_nxt = w_ovf ? VAL_MIN : q_neg;
    end else begin
      w_ovf = div_quo[VALUE_WIDTH-1];
      w_nxt = w_ovf ? VAL_MAX : div_quo;
    end
    w_half = w_nxt >>> 1;
  end

  // Walk the midpoints: start at lower bound plus half a width, clamp the current one, advance by one width
  always_comb begin
    x_top  = x_r[XW-1:VALUE_WIDTH-1];
    x_fits = (&x_top) | (~|x_top);
    if (x_fits) begin
      pt_x_nxt = x_r[VALUE_WIDTH-1:0];
    end else if (x_r[XW-1]) begin
      pt_x_nxt = VAL_MIN;
    end else begin
      pt_x_nxt = VAL_MAX;
    end
    pt_ctl_nxt.valid = issue_en;
    pt_ctl_nxt.last  = issue_last;
    pt_ctl_nxt.clip  = ~x_fits;
    x_nxt   = x_r;
    idx_nxt = idx_r;
    if (w_load) begin
      x_nxt   = XW'(lower_r) + XW'(w_half);
      idx_nxt = '0;
    end else if (issue_en) begin
      x_nxt   = x_r + XW'(w_r);
      idx_nxt = idx_r + 1'b1;
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      pt_ctl_r     <= '0;
      acc_done_r   <= 1'b0;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      pt_ctl_r   <= pt_ctl_nxt;
      acc_done_r <= acc_done_nxt;
      if (out_load) begin
        out_tvalid_r <= 1'b1;
      end else if (out_tready) begin
        out_tvalid_r <= 1'b0;
      end
    end
  end

  // Item registers and issue stage
  always_ff @(posedge clk) begin
    if (in_accept) begin
      lower_r <= in_lower;
      n_r     <= in_count;
      bad_r   <= (in_count == '0);
      neg_r   <= in_diff[VALUE_WIDTH];
    end
    if (w_load) begin
      w_r         <= w_nxt;
      item_clip_r <= w_ovf;
    end
    x_r    <= x_nxt;
    idx_r  <= idx_nxt;
    pt_x_r <= pt_x_nxt;
  end

  // Horner steps: c3*x + c2, then *x + c1, then *x + c0
  mrsc_horner #(
    .FRAC_BITS   (FRAC_BITS),
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_h0 (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ctl  (pt_ctl_r),
    .in_acc  (coef_cubic_r),
    .in_x    (pt_x_r),
    .coef    (coef_square_r),
    .out_ctl (h0_ctl),
    .out_acc (h0_acc),
    .out_x   (h0_x)
  );

  mrsc_horner #(
    .FRAC_BITS   (FRAC_BITS),
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_h1 (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ctl  (h0_ctl),
    .in_acc  (h0_acc),
    .in_x    (h0_x),
    .coef    (coef_linear_r),
    .out_ctl (h1_ctl),
    .out_acc (h1_acc),
    .out_x   (h1_x)
  );

  mrsc_horner #(
    .FRAC_BITS   (FRAC_BITS),
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_h2 (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ctl  (h1_ctl),
    .in_acc  (h1_acc),
    .in_x    (h1_x),
    .coef    (coef_constant_r),
    .out_ctl (h2_ctl),
    .out_acc (h2_acc),
    .out_x   (h2_x)
  );

  // Rectangle area y * w
  mrsc_term #(
    .FRAC_BITS   (FRAC_BITS),
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_term (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ctl  (h2_ctl),
    .y       (h2_acc),
    .w       (w_r),
    .out_ctl (term_ctl),
    .term    (term_val)
  );

  // Saturating running sum; clear on each new word
  always_comb begin
    acc_sum      = (ACC_WIDTH+1)'(acc_r) + (ACC_WIDTH+1)'(term_val);
    acc_ovf      = acc_sum[ACC_WIDTH] ^ acc_sum[ACC_WIDTH-1];
    acc_nxt      = acc_r;
    acc_clip_nxt = acc_clip_r;
    acc_done_nxt = acc_done_r;
    if (in_accept) begin
      acc_nxt      = '0;
      acc_clip_nxt = 1'b0;
      acc_done_nxt = 1'b0;
    end else if (term_ctl.valid) begin
      if (!acc_ovf) begin
        acc_nxt = acc_sum[ACC_WIDTH-1:0];
      end else if (acc_sum[ACC_WIDTH]) begin
        acc_nxt = ACC_MIN;
      end else begin
        acc_nxt = ACC_MAX;
      end
      acc_clip_nxt = acc_clip_r | term_ctl.clip | acc_ovf;
      acc_done_nxt = acc_done_r | term_ctl.last;
    end
  end

  always_ff @(posedge clk) begin
    acc_r      <= acc_nxt;
    acc_clip_r <= acc_clip_nxt;
  end

  // Final clamp to the value range; a zero segment count gives a zero sum
  always_comb begin
    acc_top  = acc_r[ACC_WIDTH-1:VALUE_WIDTH-1];
    acc_fits = (&acc_top) | (~|acc_top);
    if (bad_r) begin
      out_sum_nxt = '0;
      out_sat_nxt = 1'b0;
    end else begin
      if (acc_fits) begin
        out_sum_nxt = acc_r[VALUE_WIDTH-1:0];
      end else if (acc_r[ACC_WIDTH-1]) begin
        out_sum_nxt = VAL_MIN;
      end else begin
        out_sum_nxt = VAL_MAX;
      end
      out_sat_nxt = acc_clip_r | item_clip_r | ~acc_fits;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (out_load) begin
      out_sum_r <= out_sum_nxt;
      out_sat_r <= out_sat_nxt;
      out_bad_r <= bad_r;
    end
  end

  assign out_tvalid              = out_tvalid_r;
  assign out_tdata               = OUT_W'(out_sum_r);
  assign out_tuser[USER_SAT_BIT] = out_sat_r;
  assign out_tuser[USER_BAD_BIT] = out_bad_r;

  // A point never reaches the sum while no item is in progress
  a_no_point_idle: assert property (@(posedge clk) disable iff (!rst_n)
    term_ctl.valid |-> state_r != ST_IDLE)
    else $error("midpoint reached the sum with no item in progress");

  // Nothing follows the last point of an item
  a_no_point_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    acc_done_r |-> !term_ctl.valid)
    else $error("midpoint arrived after the last one of the item");

  // For a nonzero count, a result is formed only after the last point has been summed
  a_finish_after_sum: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_FINISH && !bad_r) |-> acc_done_r)
    else $error("result formed before the sum was complete");

  // Points are issued only by the issue state
  a_issue_state: assert property (@(posedge clk) disable iff (!rst_n)
    pt_ctl_r.valid |-> $past(state_r) == ST_ISSUE)
    else $error("midpoint issued outside the issue state");

  // A zero segment count gives a clean zero result
  a_bad_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid_r && out_bad_r) |-> (out_sum_r == '0 && !out_sat_r))
    else $error("zero-count result carries a nonzero sum or flag");

endmodule

`default_nettype wire
